/* sv/bfs_pkg.sv */
package bfs_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_VALUE_BITS = 16;

    localparam logic CFG_FIELD_WIDTH  = 1'b0;
    localparam logic CFG_FIELD_HEIGHT = 1'b1;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        texel_x;
        logic [7:0]        texel_y;
        logic signed [15:0] texel_value;
        logic signed [23:0] coord_u;
        logic signed [23:0] coord_v;
        logic              wrap_mode;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic              sample_valid;
    } out_item_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic        is_write;
        logic        is_valid;
        logic [7:0]  wx;
        logic [7:0]  wy;
        logic [15:0] wval;
        logic [7:0]  x0;
        logic [7:0]  x1;
        logic [7:0]  y0;
        logic [7:0]  y1;
        logic [15:0] tx;
        logic [15:0] ty;
    } cmd_t;

endpackage

/* sv/bfs_front.sv */
module bfs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [8:0]       cfg_data,
    input  logic             item_valid,
    input  bfs_pkg::in_item_t item,
    output logic             cmd_valid,
    output bfs_pkg::cmd_t    cmd,
    input  logic             cmd_stall,
    output logic             item_stall
);
    import bfs_pkg::*;

    logic [8:0] w_reg, h_reg;
    logic       v_reg;
    cmd_t       c_reg;
    cmd_t       c_next;
    logic [8:0] w_eff, h_eff;

    assign w_eff = (w_reg > 9'(DEF_MAX_WIDTH)) ? 9'(DEF_MAX_WIDTH) : w_reg;
    assign h_eff = (h_reg > 9'(DEF_MAX_HEIGHT)) ? 9'(DEF_MAX_HEIGHT) : h_reg;

    function automatic logic [41:0] map_axis(input logic signed [23:0] c,
                                              input logic [8:0] sz,
                                              input logic wrap);
        logic [16:0] cc;
        logic [26:0] x;
        logic signed [10:0] i0;
        logic signed [10:0] i1;
        logic [8:0] a0, a1;
        if (wrap)
            cc = {1'b0, c[15:0]};
        else if (c < 0)
            cc = 17'd0;
        else if (c > 24'sd65536)
            cc = 17'd65536;
        else
            cc = c[16:0];
        x  = 27'(cc) * 27'(sz) + 27'd32768;
        i0 = 11'(x[26:16]) - 11'sd1;
        i1 = i0 + 11'sd1;
        if (wrap)
        begin
            a0 = (i0 < 0) ? 9'(11'(i0) + 11'(sz)) : i0[8:0];
            a1 = (i1 >= $signed({2'b0, sz})) ? 9'(11'(i1) - 11'(sz)) : i1[8:0];
        end
        else
        begin
            a0 = (i0 < 0) ? 9'd0 : i0[8:0];
            a1 = (i1 > $signed({2'b0, sz}) - 11'sd1) ? 9'(sz - 9'd1) : i1[8:0];
        end
        return {a0, a1, 8'd0, x[15:0]};
    endfunction

    logic [41:0] mx, my;
    assign mx = map_axis(item.coord_u, w_eff, item.wrap_mode);
    assign my = map_axis(item.coord_v, h_eff, item.wrap_mode);

    always_comb
    begin
        c_next          = '0;
        c_next.is_write = (item.kind == KIND_WRITE);
        c_next.is_valid = (w_eff != 9'd0) && (h_eff != 9'd0);
        c_next.wx       = item.texel_x;
        c_next.wy       = item.texel_y;
        c_next.wval     = item.texel_value;
        c_next.x0       = mx[40:33];
        c_next.x1       = mx[31:24];
        c_next.y0       = my[40:33];
        c_next.y1       = my[31:24];
        c_next.tx       = mx[15:0];
        c_next.ty       = my[15:0];
    end

    assign item_stall = v_reg && cmd_stall;
    assign cmd_valid  = v_reg;
    assign cmd        = c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
            h_reg <= '0;
            v_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_FIELD_WIDTH)
                w_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_FIELD_HEIGHT)
                h_reg <= cfg_data;
            if (!item_stall)
                v_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
            c_reg <= c_next;
    end
endmodule

/* sv/bfs_back.sv */
module bfs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  bfs_pkg::cmd_t     cmd,
    output logic              cmd_stall,
    output logic              out_valid,
    output bfs_pkg::out_item_t out_item,
    input  logic              out_stall
);
    import bfs_pkg::*;

    // Four copies of the store give four reads a cycle.
    logic [15:0] mem0 [65536];
    logic [15:0] mem1 [65536];
    logic [15:0] mem2 [65536];
    logic [15:0] mem3 [65536];

    logic [15:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [15:0] tx_reg, ty_reg;
    logic        s1v_reg, s1ok_reg;
    logic signed [15:0] top_reg, bot_reg;
    logic [15:0] ty2_reg;
    logic        s2v_reg, s2ok_reg;
    logic        ov_reg;
    out_item_t   o_reg;
    logic        adv;
    logic        take;

    function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [15:0] t);
        logic signed [17:0] d;
        logic signed [35:0] p;
        d = 18'(b) - 18'(a);
        p = $signed({20'd0, t}) * 36'(d) + 36'sd32768;
        return 16'(18'(a) + 18'(p >>> 16));
    endfunction

    assign adv       = !(ov_reg && out_stall);
    assign take      = cmd_valid && adv;
    assign cmd_stall = !adv;
    assign out_valid = ov_reg;
    assign out_item  = o_reg;

    always_ff @(posedge clk)
    begin
        if (take && cmd.is_write)
        begin
            mem0[{cmd.wy, cmd.wx}] <= cmd.wval;
            mem1[{cmd.wy, cmd.wx}] <= cmd.wval;
            mem2[{cmd.wy, cmd.wx}] <= cmd.wval;
            mem3[{cmd.wy, cmd.wx}] <= cmd.wval;
        end
        if (adv)
        begin
            r0_reg   <= mem0[{cmd.y0, cmd.x0}];
            r1_reg   <= mem1[{cmd.y0, cmd.x1}];
            r2_reg   <= mem2[{cmd.y1, cmd.x0}];
            r3_reg   <= mem3[{cmd.y1, cmd.x1}];
            tx_reg   <= cmd.tx;
            ty_reg   <= cmd.ty;
            s1ok_reg <= cmd.is_valid;
            top_reg  <= lerp(r0_reg, r1_reg, tx_reg);
            bot_reg  <= lerp(r2_reg, r3_reg, tx_reg);
            ty2_reg  <= ty_reg;
            s2ok_reg <= s1ok_reg;
            o_reg.sample_value <= s2ok_reg ? lerp(top_reg, bot_reg, ty2_reg) : 16'sd0;
            o_reg.sample_valid <= s2ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1v_reg <= 1'b0;
            s2v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1v_reg <= take && !cmd.is_write;
            s2v_reg <= s1v_reg;
            ov_reg  <= s2v_reg;
        end
    end
endmodule

/* sv/bilinear_field_sampler_core.sv */
// Bilinear field sampler with wrap and clamp addressing.
// A sample item passes the front command, store read, row blend and output registers in order.
// Throughput: one item per cycle unless out_stall holds it, set by four parallel store reads.
// Reset clears the handshake state and both size registers; texels are undefined until written.
module bilinear_field_sampler_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [8:0]        cfg_data,
    input  logic              in_valid,
    input  bfs_pkg::in_item_t in_item,
    output logic              in_stall,
    output logic              out_valid,
    output bfs_pkg::out_item_t out_item,
    input  logic              out_stall
);
    import bfs_pkg::*;

    logic cv, cs;
    cmd_t c;

    bfs_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item_valid(in_valid), .item(in_item),
        .cmd_valid(cv), .cmd(c), .cmd_stall(cs), .item_stall(in_stall)
    );

    bfs_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cv), .cmd(c), .cmd_stall(cs),
        .out_valid(out_valid), .out_item(out_item), .out_stall(out_stall)
    );
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bfs_pkg::*;

    localparam int LATENCY     = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_index = CFG_FIELD_WIDTH;
    logic [8:0] cfg_data = '0;
    logic      in_valid = 1'b0;
    in_item_t  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    out_item_t out_item;
    logic      out_stall = 1'b0;

    bilinear_field_sampler_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_item(in_item),
        .in_stall(in_stall),
        .out_valid(out_valid),
        .out_item(out_item),
        .out_stall(out_stall)
    );

    always #2 clk = ~clk;

    // Model state: texels are updated as items are accepted, sizes follow the configuration port.
    logic signed [15:0] texels [0:65535];
    logic [8:0]         model_width = '0;
    logic [8:0]         model_height = '0;
    // Stimulus-side record of which texels have been given a value.
    bit                 texel_loaded [0:65535];

    in_item_t  pending_items [$];
    out_item_t expected_samples [$];
    int        mismatches = 0;
    int        cycle_count = 0;
    bit        calm = 1'b0;
    bit        long_hold_req = 1'b0;
    bit        long_hold_done = 1'b0;
    int        hold_left = 0;
    int        send_gap = 0;
    int        recv_gap = 0;

    function automatic longint texel_at(longint a, longint b, longint w, longint h, bit wrap);
        if (wrap)
        begin
            a = ((a % w) + w) % w;
            b = ((b % h) + h) % h;
        end
        else
        begin
            a = (a < 0) ? 0 : ((a > w - 1) ? w - 1 : a);
            b = (b < 0) ? 0 : ((b > h - 1) ? h - 1 : b);
        end
        return longint'(texels[b * DEF_MAX_WIDTH + a]);
    endfunction

    function automatic void axis_map(longint c, longint size, bit wrap,
                                     output longint idx, output longint frac);
        longint x;
        if (wrap)
            c = c & 65535;
        else
            c = (c < 0) ? 0 : ((c > 65536) ? 65536 : c);
        x = c * size - 32768 + 65536;
        idx = (x >>> 16) - 1;
        frac = x & 65535;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + ((t * (b - a) + 32768) >>> 16);
    endfunction

    function automatic out_item_t predict_sample(in_item_t it);
        longint w, h, ix, iy, tx, ty, top, bot;
        out_item_t r;
        r = '0;
        w = (model_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : model_width;
        h = (model_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : model_height;
        if (w == 0 || h == 0)
            return r;
        axis_map(longint'($signed(it.coord_u)), w, it.wrap_mode, ix, tx);
        axis_map(longint'($signed(it.coord_v)), h, it.wrap_mode, iy, ty);
        top = blend(texel_at(ix, iy, w, h, it.wrap_mode),
                    texel_at(ix + 1, iy, w, h, it.wrap_mode), tx);
        bot = blend(texel_at(ix, iy + 1, w, h, it.wrap_mode),
                    texel_at(ix + 1, iy + 1, w, h, it.wrap_mode), tx);
        r.sample_value = 16'(blend(top, bot, ty));
        r.sample_valid = 1'b1;
        return r;
    endfunction

    task automatic absorb_item(in_item_t it);
        if (it.kind == KIND_WRITE)
            texels[{it.texel_y, it.texel_x}] = it.texel_value;
        else
            expected_samples.push_back(predict_sample(it));
    endtask

    // Sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_item(in_item);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 15) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here.
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (long_hold_req && !long_hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
    end

    // Receiver and checker.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_item;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected item: value %0d valid %0b",
                                 out_item.sample_value, out_item.sample_valid);
                end
                else
                begin
                    exp_item = expected_samples.pop_front();
                    if (exp_item.sample_value !== out_item.sample_value ||
                        exp_item.sample_valid !== out_item.sample_valid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Mismatch: expected value %0d valid %0b, ",
                                      "got value %0d valid %0b"},
                                     exp_item.sample_value, exp_item.sample_valid,
                                     out_item.sample_value, out_item.sample_valid);
                    end
                end
            end
            if (hold_left > 0)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 11) == 0)
                    recv_gap = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic in_item_t write_item(logic [7:0] x, logic [7:0] y, logic [15:0] val);
        in_item_t it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.kind = KIND_WRITE;
        it.texel_x = x;
        it.texel_y = y;
        it.texel_value = val;
        texel_loaded[{y, x}] = 1'b1;
        return it;
    endfunction

    function automatic in_item_t sample_item(int u, int v, bit wrap);
        in_item_t it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.kind = KIND_SAMPLE;
        it.coord_u = 24'(u);
        it.coord_v = 24'(v);
        it.wrap_mode = wrap;
        return it;
    endfunction

    function automatic int random_coord();
        case ($urandom_range(0, 3))
            0: return int'(24'($urandom));
            1: return int'($urandom_range(0, 327680)) - 131072;
            2: return int'($urandom_range(0, 65536));
            default: return int'($urandom_range(0, 15)) - 8 +
                            ($urandom_range(0, 1) ? 65536 : 0);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [8:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int w, int h, int samples, bit directed);
        int ew, eh;
        int extremes [6];
        wait_idle();
        write_register(CFG_FIELD_WIDTH, 9'(w));
        write_register(CFG_FIELD_HEIGHT, 9'(h));
        @(posedge clk);
        ew = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
        eh = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
                if (!texel_loaded[y * DEF_MAX_WIDTH + x] || directed)
                    pending_items.push_back(write_item(8'(x), 8'(y), 16'($urandom)));
        if (directed)
        begin
            pending_items.push_back(write_item(8'd0, 8'd0, 16'sh7fff));
            pending_items.push_back(write_item(8'd1, 8'd0, 16'sh8000));
            pending_items.push_back(write_item(8'd0, 8'd1, 16'sh8000));
            pending_items.push_back(write_item(8'd255, 8'd255, 16'sh7fff));
            extremes = '{-8388608, 8388607, 0, 65536, 32768, -1};
            for (int i = 0; i < 6; i++)
            begin
                pending_items.push_back(sample_item(extremes[i], extremes[5 - i], 1'b0));
                pending_items.push_back(sample_item(extremes[i], extremes[(i + 2) % 6], 1'b1));
            end
        end
        for (int i = 0; i < samples; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                if ($urandom_range(0, 1) && ew > 0 && eh > 0)
                    pending_items.push_back(write_item(8'($urandom_range(0, ew - 1)),
                                                       8'($urandom_range(0, eh - 1)),
                                                       16'($urandom)));
                else
                    pending_items.push_back(write_item(8'($urandom), 8'($urandom),
                                                       16'($urandom)));
            end
            pending_items.push_back(sample_item(random_coord(), random_coord(),
                                                1'($urandom_range(0, 1))));
        end
    endtask

    initial
    begin
        for (int i = 0; i < 65536; i++)
        begin
            texels[i] = '0;
            texel_loaded[i] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_phase(0, 0, 20, 1'b0);
        run_phase(4, 4, 0, 1'b1);
        run_phase(4, 4, 30, 1'b0);
        run_phase(0, 7, 10, 1'b0);
        run_phase(9, 0, 10, 1'b0);
        run_phase(1, 1, 20, 1'b0);
        run_phase(2, 2, 30, 1'b0);
        run_phase(256, 1, 30, 1'b0);
        run_phase(1, 256, 30, 1'b0);
        run_phase(511, 1, 30, 1'b0);
        run_phase(1, 511, 30, 1'b0);
        long_hold_req <= 1'b1;
        run_phase(16, 16, 90, 1'b0);
        run_phase(7, 5, 30, 1'b0);
        run_phase(2, 256, 30, 1'b0);
        run_phase(5, 13, 30, 1'b0);
        wait_idle();
        calm = 1'b1;
        run_phase(6, 6, 40, 1'b0);
        wait_idle();
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Model copy of the size registers follows the configuration port.
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
        begin
            if (cfg_index == CFG_FIELD_WIDTH)
                model_width <= cfg_data;
            else
                model_height <= cfg_data;
        end
    end

endmodule
